/* hw/rtl/mmm_pkg.sv */
// mmm_pkg: shared constants, types and helper functions of the montgomery multiplier
// no dependencies; compiled first

package mmm_pkg;

	localparam int MAX_WORDS = 4;
	localparam int IDX_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CNT_W     = $clog2(MAX_WORDS + 1);
	localparam int DIGIT_W   = 64;

	typedef logic [DIGIT_W-1:0] digit_t;

	localparam int MOD_REGS = 4;
	localparam int MOD_IW   = $clog2(MOD_REGS);
	typedef logic [MOD_REGS-1:0][DIGIT_W-1:0] mod_arr_t;

	localparam int PADDR_W     = 6;
	localparam int PDATA_W     = 64;
	localparam int REG_IW      = 3;
	localparam int NUM_WORDS_W = 3;

	localparam logic [REG_IW-1:0] REG_MOD0      = 3'd0;
	localparam logic [REG_IW-1:0] REG_MOD1      = 3'd1;
	localparam logic [REG_IW-1:0] REG_MOD2      = 3'd2;
	localparam logic [REG_IW-1:0] REG_MOD3      = 3'd3;
	localparam logic [REG_IW-1:0] REG_NPRIME    = 3'd4;
	localparam logic [REG_IW-1:0] REG_NUM_WORDS = 3'd5;

	localparam logic [NUM_WORDS_W-1:0] NUM_WORDS_RST = 3'd4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int MAC_STEPS = 4;
	localparam int MAC_CNT_W = 3;

	typedef struct packed {
		digit_t           a;
		digit_t           b;
		logic [IDX_W-1:0] idx;
		logic             last;
		logic [CNT_W-1:0] n;
	} q_item_t;

	typedef struct packed {
		logic   start;
		digit_t x;
		digit_t y;
		digit_t t;
		digit_t c;
	} mac_req_t;

	typedef struct packed {
		logic   done;
		digit_t lo;
		digit_t hi;
	} mac_rsp_t;

	// digit count in use: zero acts as one, large values clamp
	function automatic logic [CNT_W-1:0] eff_words(input logic [NUM_WORDS_W-1:0] nw);
		if (nw == '0) begin
			return CNT_W'(1);
		end else if (int'(nw) > MAX_WORDS) begin
			return CNT_W'(MAX_WORDS);
		end
		return CNT_W'(nw);
	endfunction

	// modulus digits beyond the register set read as zero
	function automatic digit_t mod_digit(input mod_arr_t m, input logic [IDX_W-1:0] j);
		if (int'(j) < MOD_REGS) begin
			return m[MOD_IW'(j)];
		end
		return '0;
	endfunction

endpackage

/* hw/rtl/mmm_if.sv */
// mmm_if: valid/ready channel interfaces for operand digits and product digits
// depends on mmm_pkg

interface mmm_operand_if;
	import mmm_pkg::*;
	logic   valid;
	logic   ready;
	digit_t a_digit;
	digit_t b_digit;
	modport source(output valid, output a_digit, output b_digit, input ready);
	modport sink(input valid, input a_digit, input b_digit, output ready);
endinterface

interface mmm_product_if;
	import mmm_pkg::*;
	logic   valid;
	logic   ready;
	digit_t product_digit;
	logic   last_digit;
	modport source(output valid, output product_digit, output last_digit, input ready);
	modport sink(input valid, input product_digit, input last_digit, output ready);
endinterface

/* hw/rtl/mmm_front.sv */
// mmm_front: accepts operand items, numbers each digit and marks the last one of a load
// depends on mmm_pkg and mmm_if

module mmm_front (
	input  logic                               clk,
	input  logic                               arst_n,
	mmm_operand_if.sink                        operand,
	input  logic [mmm_pkg::NUM_WORDS_W-1:0]    num_words,
	output logic                               push_valid,
	input  logic                               push_ready,
	output mmm_pkg::q_item_t                   push_item
);
	import mmm_pkg::*;

	logic [IDX_W-1:0] load_q;
	logic [CNT_W-1:0] n_cur;
	logic             is_last;

	assign n_cur   = eff_words(num_words);
	assign is_last = (CNT_W'(load_q) + CNT_W'(1)) >= n_cur;

	assign operand.ready   = push_ready;
	assign push_valid      = operand.valid;
	assign push_item.a     = operand.a_digit;
	assign push_item.b     = operand.b_digit;
	assign push_item.idx   = load_q;
	assign push_item.last  = is_last;
	assign push_item.n     = n_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
		end else if (operand.valid && push_ready) begin
			load_q <= is_last ? '0 : load_q + IDX_W'(1);
		end
	end

endmodule

/* hw/rtl/mmm_fifo.sv */
// mmm_fifo: short queue of classified items between front and back
// depends on mmm_pkg

module mmm_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  mmm_pkg::q_item_t  push_item,
	output logic              pop_valid,
	input  logic              pop_ready,
	output mmm_pkg::q_item_t  pop_item
);
	import mmm_pkg::*;

	q_item_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != (QPTR_W+1)'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QDEPTH))
		else $error("queue count above depth");

endmodule

/* hw/rtl/mmm_mac.sv */
// mmm_mac: 64x64 multiply-accumulate t + x*y + c over four passes of a 32x32 multiplier
// depends on mmm_pkg

module mmm_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  mmm_pkg::mac_req_t req,
	output mmm_pkg::mac_rsp_t rsp
);
	import mmm_pkg::*;

	digit_t                 x_q;
	digit_t                 y_q;
	logic [2*DIGIT_W-1:0]   acc_q;
	logic [MAC_CNT_W-1:0]   cnt_q;
	logic                   run_q;
	logic                   done_q;
	logic [DIGIT_W-1:0]     pp_s1;
	logic [1:0]             sel_s1;
	logic                   pv_s1;
	logic [DIGIT_W/2-1:0]   x_half;
	logic [DIGIT_W/2-1:0]   y_half;
	logic [DIGIT_W-1:0]     prod;
	logic [1:0]             sh;
	logic [2*DIGIT_W-1:0]   pp_shifted;
	logic                   mul_step;

	assign x_half     = cnt_q[0] ? x_q[DIGIT_W-1:DIGIT_W/2] : x_q[DIGIT_W/2-1:0];
	assign y_half     = cnt_q[1] ? y_q[DIGIT_W-1:DIGIT_W/2] : y_q[DIGIT_W/2-1:0];
	assign prod       = x_half * y_half;
	assign sh         = {1'b0, sel_s1[0]} + {1'b0, sel_s1[1]};
	assign pp_shifted = {{DIGIT_W{1'b0}}, pp_s1} << {sh, 5'd0};
	assign mul_step   = run_q && (cnt_q < MAC_CNT_W'(MAC_STEPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && run_q && (cnt_q == MAC_CNT_W'(MAC_STEPS));
			pv_s1  <= mul_step && !req.start;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + MAC_CNT_W'(1);
				if (cnt_q == MAC_CNT_W'(MAC_STEPS)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= req.x;
			y_q   <= req.y;
			acc_q <= {{(DIGIT_W-1){1'b0}}, {1'b0, req.t} + {1'b0, req.c}};
		end else begin
			if (mul_step) begin
				pp_s1  <= prod;
				sel_s1 <= cnt_q[1:0];
			end
			if (pv_s1) begin
				acc_q <= acc_q + pp_shifted;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.lo   = acc_q[DIGIT_W-1:0];
	assign rsp.hi   = acc_q[2*DIGIT_W-1:DIGIT_W];

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !run_q)
		else $error("multiply started while busy");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q))
		else $error("multiply done without a running pass");

endmodule

/* hw/rtl/mmm_core.sv */
// mmm_core: back end; stores loaded digits, runs the interleaved multiply-reduce rows,
// the final conditional subtraction and the product output register. depends on mmm_pkg, mmm_if

module mmm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  mmm_pkg::q_item_t  q_item,
	input  mmm_pkg::mod_arr_t modulus,
	input  mmm_pkg::digit_t   nprime,
	output mmm_pkg::mac_req_t mac_req,
	input  mmm_pkg::mac_rsp_t mac_rsp,
	mmm_product_if.source     product
);
	import mmm_pkg::*;

	typedef enum logic [3:0] {
		S_LOAD, S_A_ISSUE, S_A_WAIT, S_A_TOP, S_M_ISSUE, S_M_WAIT,
		S_R_ISSUE, S_R_WAIT, S_R_TOP, S_SUB, S_EMIT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] row_q;
	logic [CNT_W-1:0] n_q;
	logic             out_valid_q;
	digit_t           out_digit_q;
	logic             out_last_q;

	digit_t           a_q    [MAX_WORDS];
	digit_t           b_q    [MAX_WORDS];
	digit_t           t_q    [MAX_WORDS];
	digit_t           diff_q [MAX_WORDS];
	digit_t           top0_q;
	logic             top1_q;
	digit_t           carry_q;
	digit_t           m_q;
	logic             borrow_q;

	digit_t           rd_t;
	digit_t           n_dig;
	logic             last_col;
	logic             last_row;
	logic             pop;
	logic             emit_go;
	logic             ge;
	logic [DIGIT_W:0] sum_top;
	logic [DIGIT_W:0] sub_d;
	logic             borrow_in;

	assign rd_t      = t_q[col_q];
	assign n_dig     = mod_digit(modulus, col_q);
	assign last_col  = (CNT_W'(col_q) + CNT_W'(1)) == n_q;
	assign last_row  = (CNT_W'(row_q) + CNT_W'(1)) == n_q;
	assign q_ready   = state_q == S_LOAD;
	assign pop       = q_valid && q_ready;
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || product.ready);
	assign ge        = (top0_q != '0) || !borrow_q;
	assign sum_top   = {1'b0, top0_q} + {1'b0, carry_q};
	assign borrow_in = (col_q != '0) && borrow_q;
	assign sub_d     = {1'b0, rd_t} - {1'b0, n_dig} - (DIGIT_W+1)'(borrow_in);

	always_comb begin
		mac_req.start = 1'b0;
		mac_req.x     = a_q[col_q];
		mac_req.y     = b_q[row_q];
		mac_req.t     = rd_t;
		mac_req.c     = (col_q == '0) ? '0 : carry_q;
		unique case (state_q)
			S_A_ISSUE: begin
				mac_req.start = 1'b1;
			end
			S_M_ISSUE: begin
				mac_req.start = 1'b1;
				mac_req.x     = rd_t;
				mac_req.y     = nprime;
				mac_req.t     = '0;
				mac_req.c     = '0;
			end
			S_R_ISSUE: begin
				mac_req.start = 1'b1;
				mac_req.x     = m_q;
				mac_req.y     = n_dig;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			col_q       <= '0;
			row_q       <= '0;
			n_q         <= CNT_W'(1);
			out_valid_q <= 1'b0;
			out_digit_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (product.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (pop && q_item.last) begin
						n_q     <= q_item.n;
						col_q   <= '0;
						row_q   <= '0;
						state_q <= S_A_ISSUE;
					end
				end
				S_A_ISSUE: state_q <= S_A_WAIT;
				S_A_WAIT: begin
					if (mac_rsp.done) begin
						if (last_col) begin
							state_q <= S_A_TOP;
						end else begin
							col_q   <= col_q + IDX_W'(1);
							state_q <= S_A_ISSUE;
						end
					end
				end
				S_A_TOP: begin
					col_q   <= '0;
					state_q <= S_M_ISSUE;
				end
				S_M_ISSUE: state_q <= S_M_WAIT;
				S_M_WAIT: begin
					if (mac_rsp.done) begin
						state_q <= S_R_ISSUE;
					end
				end
				S_R_ISSUE: state_q <= S_R_WAIT;
				S_R_WAIT: begin
					if (mac_rsp.done) begin
						if (last_col) begin
							state_q <= S_R_TOP;
						end else begin
							col_q   <= col_q + IDX_W'(1);
							state_q <= S_R_ISSUE;
						end
					end
				end
				S_R_TOP: begin
					col_q <= '0;
					if (last_row) begin
						state_q <= S_SUB;
					end else begin
						row_q   <= row_q + IDX_W'(1);
						state_q <= S_A_ISSUE;
					end
				end
				S_SUB: begin
					if (last_col) begin
						col_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						col_q <= col_q + IDX_W'(1);
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_digit_q <= ge ? diff_q[col_q] : rd_t;
						out_last_q  <= last_col;
						if (last_col) begin
							col_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							col_q <= col_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// digit stores and accumulator
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LOAD: begin
				if (pop) begin
					a_q[q_item.idx] <= q_item.a;
					b_q[q_item.idx] <= q_item.b;
					if (q_item.last) begin
						for (int k = 0; k < MAX_WORDS; k++) begin
							t_q[k] <= '0;
						end
						top0_q <= '0;
						top1_q <= 1'b0;
					end
				end
			end
			S_A_WAIT: begin
				if (mac_rsp.done) begin
					t_q[col_q] <= mac_rsp.lo;
					carry_q    <= mac_rsp.hi;
				end
			end
			S_A_TOP: begin
				top0_q <= sum_top[DIGIT_W-1:0];
				top1_q <= sum_top[DIGIT_W];
			end
			S_M_WAIT: begin
				if (mac_rsp.done) begin
					m_q <= mac_rsp.lo;
				end
			end
			S_R_WAIT: begin
				if (mac_rsp.done) begin
					if (col_q != '0) begin
						t_q[col_q - IDX_W'(1)] <= mac_rsp.lo;
					end
					carry_q <= mac_rsp.hi;
				end
			end
			S_R_TOP: begin
				t_q[IDX_W'(n_q - CNT_W'(1))] <= sum_top[DIGIT_W-1:0];
				top0_q <= DIGIT_W'(top1_q) + DIGIT_W'(sum_top[DIGIT_W]);
				top1_q <= 1'b0;
			end
			S_SUB: begin
				diff_q[col_q] <= sub_d[DIGIT_W-1:0];
				borrow_q      <= sub_d[DIGIT_W];
			end
			default: ;
		endcase
	end

	assign product.valid         = out_valid_q;
	assign product.product_digit = out_digit_q;
	assign product.last_digit    = out_last_q;

	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_LOAD |-> (n_q != '0) && (n_q <= CNT_W'(MAX_WORDS)))
		else $error("digit count out of range during a product");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_LOAD |-> (CNT_W'(col_q) < n_q) && (CNT_W'(row_q) < n_q))
		else $error("row or column index beyond digit count");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_rsp.done |-> (state_q == S_A_WAIT) || (state_q == S_M_WAIT) ||
			(state_q == S_R_WAIT))
		else $error("multiply result arrived outside a wait state");

endmodule

/* hw/rtl/montgomery_modular_multiplier.sv */
// montgomery_modular_multiplier: top level with configuration registers
// depends on mmm_pkg, mmm_if, mmm_front, mmm_fifo, mmm_mac, mmm_core
//
// usage:
// operand channel: one item per 64-bit digit pair of A and B, least significant first.
// after num_words items (1..4, zero acts as one) the product U = A*B*R^-1 mod N is
// computed and returned as num_words items on the product channel, the last one flagged.
// modulus digits, n'0 and num_words are written over the APB port at byte address 8*i;
// the user must do so only while the block is idle, which the block does not enforce.
// reads return the register values. each 64x64 multiply-accumulate runs on one 32x32
// multiplier used four times, and each row of the product needs 2n+1 of them.
// a four-entry queue lets the next operand load be accepted while a product is computed
// or waits at the output; a stalled receiver holds the output register and the sequencer,
// and once the queue fills operand ready drops.
// reset: asynchronous, clears control, modulus and n'0 to zero, num_words to four.

module montgomery_modular_multiplier (
	input  logic                          clk,
	input  logic                          arst_n,
	mmm_operand_if.sink                   operand,
	mmm_product_if.source                 product,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mmm_pkg::PADDR_W-1:0]   paddr,
	input  logic [mmm_pkg::PDATA_W-1:0]   pwdata,
	output logic [mmm_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import mmm_pkg::*;

	mod_arr_t               mod_q;
	digit_t                 nprime_q;
	logic [NUM_WORDS_W-1:0] num_words_q;
	logic [REG_IW-1:0]      reg_idx;
	logic                   wr_en;

	logic                   push_valid;
	logic                   push_ready;
	q_item_t                push_item;
	logic                   pop_valid;
	logic                   pop_ready;
	q_item_t                pop_item;
	mac_req_t               mac_req;
	mac_rsp_t               mac_rsp;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q       <= '0;
			nprime_q    <= '0;
			num_words_q <= NUM_WORDS_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MOD0:      mod_q[0]    <= pwdata;
				REG_MOD1:      mod_q[1]    <= pwdata;
				REG_MOD2:      mod_q[2]    <= pwdata;
				REG_MOD3:      mod_q[3]    <= pwdata;
				REG_NPRIME:    nprime_q    <= pwdata;
				REG_NUM_WORDS: num_words_q <= pwdata[NUM_WORDS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MOD0:      prdata = mod_q[0];
			REG_MOD1:      prdata = mod_q[1];
			REG_MOD2:      prdata = mod_q[2];
			REG_MOD3:      prdata = mod_q[3];
			REG_NPRIME:    prdata = nprime_q;
			REG_NUM_WORDS: prdata = PDATA_W'(num_words_q);
			default:       prdata = '0;
		endcase
	end

	mmm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.operand    (operand),
		.num_words  (num_words_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	mmm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	mmm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	mmm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.q_item  (pop_item),
		.modulus (mod_q),
		.nprime  (nprime_q),
		.mac_req (mac_req),
		.mac_rsp (mac_rsp),
		.product (product)
	);

endmodule
